// ----- src/lpd_pkg.sv -----
package lpd_pkg;

   // Packet layout on the serial link.
   localparam logic [4:0] PKT_CHK_LO_POS = 5'd20;
   localparam logic [4:0] PKT_LAST_POS   = 5'd21;
   localparam int         CHK_BITS       = 15;
   // Ten 16-bit words, each fold shifts left once: 16 + 10 bits.
   localparam int         ACC_W          = 26;

   // Configuration register indexes.
   localparam logic CSR_SYNC_BYTE  = 1'b0;
   localparam logic CSR_INDEX_BASE = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [7:0] SYNC_BYTE_RESET  = 8'd250;
   localparam logic [7:0] INDEX_BASE_RESET = 8'd160;

   // Packets held between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      FRONT_HUNT,
      FRONT_COLLECT
   } front_state_type;

   // One raw reading as it arrives, low byte first.
   typedef struct packed {
      logic [7:0] int_hi;
      logic [7:0] int_lo;
      logic [7:0] dist_hi;
      logic [7:0] dist_lo;
   } reading_type;

   // A finished packet, as handed from the front to the back.
   typedef struct packed {
      logic                  bad;
      logic [7:0]            base_angle;
      logic [15:0]           speed;
      reading_type [3:0]     readings;
   } pkt_desc_type;

endpackage

// ----- src/lpd_front.sv -----
module lpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [7:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   output logic                  push,
   output lpd_pkg::pkt_desc_type push_desc,
   input  logic                  queue_full
);
   import lpd_pkg::*;

   front_state_type    state_ff, state_in;
   logic [4:0]         count_ff, count_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [7:0]         lo_ff, lo_in;
   logic [CHK_BITS-1:0] chk_ff, chk_in;
   logic [7:0]         sync_ff, base_ff;
   logic [7:0]         pkt_ff [0:19];
   logic               accept;
   logic               final_byte;
   logic [15:0]        fold_sum;

   assign accept     = req_tvalid && req_tready;
   assign final_byte = (state_ff == FRONT_COLLECT) && (count_ff == PKT_LAST_POS);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_BYTE_RESET;
         base_ff <= INDEX_BASE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SYNC_BYTE:  sync_ff <= csr_wdata;
            CSR_INDEX_BASE: base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state: hunt for the sync byte, then collect a whole packet.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_HUNT: begin
            if (accept && req_tdata == sync_ff) state_in = FRONT_COLLECT;
         end
         FRONT_COLLECT: begin
            if (accept && count_ff == PKT_LAST_POS) state_in = FRONT_HUNT;
         end
         default: state_in = FRONT_HUNT;
      endcase
   end

   // Outputs: the closing byte waits only when the queue has no room.
   always_comb begin
      req_tready = !(final_byte && queue_full);
      push       = accept && final_byte;
   end

   // Fold of the running checksum down to 15 bits.
   assign fold_sum = {1'b0, acc_ff[CHK_BITS-1:0]}
                   + {{(16 - (ACC_W - CHK_BITS)){1'b0}}, acc_ff[ACC_W-1:CHK_BITS]};

   // Byte position, word pairing and checksum update.
   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      chk_in   = chk_ff;
      if (accept) begin
         if (state_ff == FRONT_HUNT) begin
            if (req_tdata == sync_ff) begin
               count_in = 5'd1;
               acc_in   = '0;
               lo_in    = req_tdata;
            end
         end else begin
            if (count_ff == PKT_LAST_POS) begin
               count_in = '0;
            end else begin
               count_in = count_ff + 5'd1;
            end
            if (!count_ff[0]) begin
               lo_in = req_tdata;
            end else if (count_ff < PKT_CHK_LO_POS) begin
               acc_in = {acc_ff[ACC_W-2:0], 1'b0} + {{(ACC_W - 16){1'b0}}, req_tdata, lo_ff};
            end
            if (count_ff == PKT_CHK_LO_POS) chk_in = fold_sum[CHK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_HUNT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      chk_ff <= chk_in;
   end

   // Packet bytes, written at their position and read at fixed places.
   always_ff @(posedge clock) begin
      if (accept && state_ff == FRONT_COLLECT && count_ff < PKT_CHK_LO_POS) begin
         pkt_ff[count_ff] <= req_tdata;
      end
   end

   // Descriptor of the packet that the current byte closes.
   always_comb begin
      push_desc.bad        = {req_tdata, lo_ff} != {1'b0, chk_ff};
      push_desc.base_angle = pkt_ff[1] - base_ff;
      push_desc.speed      = {pkt_ff[3], pkt_ff[2]};
      for (int k = 0; k < 4; k++) begin
         push_desc.readings[k].dist_lo = pkt_ff[4 + 4 * k];
         push_desc.readings[k].dist_hi = pkt_ff[5 + 4 * k];
         push_desc.readings[k].int_lo  = pkt_ff[6 + 4 * k];
         push_desc.readings[k].int_hi  = pkt_ff[7 + 4 * k];
      end
   end

endmodule

// ----- src/lpd_queue.sv -----
module lpd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lpd_pkg::pkt_desc_type push_desc,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output lpd_pkg::pkt_desc_type pop_desc
);
   import lpd_pkg::*;

   pkt_desc_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_desc  = entry_ff[rd_ff];
   assign do_pop    = pop && pop_valid;

   // Storage; a push is only offered while there is room.
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_desc;
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         case ({push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- src/lpd_back.sv -----
module lpd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  lpd_pkg::pkt_desc_type pop_desc,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import lpd_pkg::*;

   pkt_desc_type desc_ff;
   logic         active_ff;
   logic [1:0]   slot_ff;
   logic         out_valid_ff;
   logic [55:0]  data_ff, data_in;
   logic         status_ff, status_in;
   logic         last_ff, last_in;
   logic         advance;
   logic         item_last;
   reading_type  rd;
   logic         flagged;
   logic [13:0]  dist_mm;
   logic [15:0]  inten;

   assign advance   = active_ff && (!out_valid_ff || rsp_tready);
   assign item_last = desc_ff.bad || slot_ff == 2'd3;
   assign pop       = pop_valid && (!active_ff || (advance && item_last));

   // Build the word for the current reading slot.
   always_comb begin
      rd      = desc_ff.readings[slot_ff];
      flagged = rd.dist_hi[7] || rd.dist_hi[6];
      dist_mm = flagged ? '0 : {rd.dist_hi[5:0], rd.dist_lo};
      inten   = flagged ? '0 : {rd.int_hi, rd.int_lo};
      if (desc_ff.bad) begin
         data_in   = '0;
         status_in = 1'b1;
      end else begin
         data_in   = {desc_ff.speed, inten, dist_mm, desc_ff.base_angle, slot_ff};
         status_in = 1'b0;
      end
      last_in = item_last;
   end

   // Packet being drained and the slot within it.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= '0;
      end else if (pop) begin
         active_ff <= 1'b1;
         slot_ff   <= '0;
      end else if (advance && item_last) begin
         active_ff <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) desc_ff <= pop_desc;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- src/lidar_packet_deframer_top.sv -----
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid/req_tready    req_tdata: rx_byte
// rsp_      out        rsp_tvalid/rsp_tready    tdata, tuser: status, tlast: last
// csr_      in         csr_we                   csr_addr, csr_wdata
//
// One received byte is taken every cycle. A packet closes on its 22nd byte and
// yields one word for a checksum mismatch or four readings, drained one word
// per ready cycle from an output register. A two-packet queue sits between byte
// intake and the drain; the input stalls only on a closing byte while that queue
// is full. Reset is synchronous and resets control state and config registers.
module lidar_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [9:0] angle, [23:10] distance_mm,
                                    // [39:24] intensity, [55:40] speed_raw
   output logic        rsp_tuser,   // [0] status
   output logic        rsp_tlast
);
   import lpd_pkg::*;

   logic         push, queue_full, pop, pop_valid;
   pkt_desc_type push_desc, pop_desc;

   lpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_desc  (push_desc),
      .queue_full (queue_full)
   );

   lpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_desc  (pop_desc)
   );

   lpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_desc   (pop_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import lpd_pkg::*;

   localparam int   PKT_BYTES     = 22;
   localparam int   HOLD_CYCLES   = 300;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   QUIET_LIMIT   = 4000;
   localparam logic STATUS_READING   = 1'b0;
   localparam logic STATUS_CHK_ERROR = 1'b1;

   // One result word as the block presents it, fields in port order.
   typedef struct packed {
      logic        status;
      logic [9:0]  angle;
      logic [13:0] distance_mm;
      logic [15:0] intensity;
      logic [15:0] speed_raw;
      logic        last;
   } reading_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_SYNC_BYTE;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;            // [9:0] angle, [23:10] distance_mm,
                                      // [39:24] intensity, [55:40] speed_raw
   logic        rsp_tuser;            // [0] status
   logic        rsp_tlast;

   // Byte stream waiting to be sent, and what has gone through so far.
   logic [7:0]  serial_bytes[$];
   int          bytes_pushed = 0;
   int          bytes_taken = 0;
   int          send_gap = 0;
   logic        req_fired = 1'b0;
   bit          idle_on = 1'b1;
   logic [7:0]  gen_sync = SYNC_BYTE_RESET;

   // Receiver side: random stalls and the long hold-off.
   int          hold_asks = 0;
   int          hold_done = 0;
   int          hold_left = 0;
   int          stall_left = 0;

   // Deframer prediction state.
   bit               framing = 1'b0;
   int               frame_count = 0;
   logic [175:0]     frame_bytes;
   logic [7:0]       sync_reg = SYNC_BYTE_RESET;
   logic [7:0]       base_reg = INDEX_BASE_RESET;
   reading_word_type readings_due[$];

   int good_packets = 0;
   int bad_packets = 0;
   int words_checked = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   lidar_packet_deframer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Fold ten little-endian words, shifting once per word, then reduce to 15 bits.
   function automatic logic [14:0] fold_checksum(input logic [159:0] body);
      logic [31:0] acc;
      logic [14:0] sum;
      int          w;
      acc = 32'd0;
      for (w = 0; w < 10; w++) begin
         acc = (acc << 1) + {16'd0, body[16*w +: 16]};
      end
      sum = acc[14:0] + acc[29:15];
      return sum;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] seen,
                              input logic [15:0] want);
      if (seen !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, seen, want));
      end
   endtask

   // Track one accepted byte through hunt and collection; queue the words a
   // completed packet produces.
   task automatic deframe_byte(input logic [7:0] rx);
      reading_word_type word;
      logic [14:0]      chk;
      logic [7:0]       base_angle;
      logic [7:0]       dist_hi;
      int               k;
      if (!framing) begin
         if (rx == sync_reg) begin
            frame_bytes[7:0] = rx;
            frame_count = 1;
            framing = 1'b1;
         end
      end else begin
         frame_bytes[8*frame_count +: 8] = rx;
         frame_count++;
         if (frame_count == PKT_BYTES) begin
            framing = 1'b0;
            frame_count = 0;
            chk = fold_checksum(frame_bytes[159:0]);
            if ({1'b0, chk} != frame_bytes[175:160]) begin
               word = '0;
               word.status = STATUS_CHK_ERROR;
               word.last = 1'b1;
               readings_due.push_back(word);
               bad_packets++;
            end else begin
               base_angle = frame_bytes[15:8] - base_reg;
               for (k = 0; k < 4; k++) begin
                  dist_hi = frame_bytes[8*(5 + 4*k) +: 8];
                  word.status = STATUS_READING;
                  word.angle = {base_angle, 2'(k)};
                  if (dist_hi[7:6] == 2'b00) begin
                     word.distance_mm = {dist_hi[5:0], frame_bytes[8*(4 + 4*k) +: 8]};
                     word.intensity = frame_bytes[8*(6 + 4*k) +: 16];
                  end else begin
                     word.distance_mm = 14'd0;
                     word.intensity = 16'd0;
                  end
                  word.speed_raw = frame_bytes[31:16];
                  word.last = (k == 3);
                  readings_due.push_back(word);
               end
               good_packets++;
            end
         end
      end
   endtask

   task automatic check_word();
      reading_word_type seen;
      reading_word_type want;
      seen = {rsp_tuser, rsp_tdata[9:0], rsp_tdata[23:10], rsp_tdata[39:24],
              rsp_tdata[55:40], rsp_tlast};
      words_checked++;
      if (readings_due.size() == 0) begin
         report_mismatch($sformatf("unexpected word %h", seen));
      end else begin
         want = readings_due.pop_front();
         check_field("status", 16'(seen.status), 16'(want.status));
         check_field("angle", 16'(seen.angle), 16'(want.angle));
         check_field("distance_mm", 16'(seen.distance_mm), 16'(want.distance_mm));
         check_field("intensity", seen.intensity, want.intensity);
         check_field("speed_raw", seen.speed_raw, want.speed_raw);
         check_field("last", 16'(seen.last), 16'(want.last));
      end
   endtask

   // Monitor: register writes, accepted bytes and result words at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         framing = 1'b0;
         frame_count = 0;
         sync_reg = SYNC_BYTE_RESET;
         base_reg = INDEX_BASE_RESET;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (csr_we) begin
            if (csr_addr == CSR_SYNC_BYTE) begin
               sync_reg = csr_wdata;
            end else begin
               base_reg = csr_wdata;
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            deframe_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_word();
         end
      end
   end

   // Driver: holds a byte until it is taken, then offers the next or idles.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fired)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (serial_bytes.size() > 0) begin
            req_tdata <= serial_bytes.pop_front();
            req_tvalid <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_done != hold_asks) begin
         hold_done++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      serial_bytes.push_back(b);
      bytes_pushed++;
   endtask

   // Random bytes that never match the current sync value.
   task automatic push_noise(input int count);
      logic [7:0] b;
      int         i;
      for (i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == gen_sync) begin
            b = ~b;
         end
         push_byte(b);
      end
   endtask

   // Readings are {intensity, distance high, distance low}; corrupt is XORed
   // onto the checksum field.
   task automatic push_packet(input logic [7:0] index, input logic [15:0] speed,
                              input logic [31:0] r0, input logic [31:0] r1,
                              input logic [31:0] r2, input logic [31:0] r3,
                              input logic [15:0] corrupt);
      logic [175:0] pkt;
      int           k;
      pkt[7:0] = gen_sync;
      pkt[15:8] = index;
      pkt[31:16] = speed;
      pkt[63:32] = r0;
      pkt[95:64] = r1;
      pkt[127:96] = r2;
      pkt[159:128] = r3;
      pkt[175:160] = {1'b0, fold_checksum(pkt[159:0])} ^ corrupt;
      for (k = 0; k < PKT_BYTES; k++) begin
         push_byte(pkt[8*k +: 8]);
      end
   endtask

   // At least half the readings keep both flag bits clear so real distances show up.
   function automatic logic [31:0] random_reading();
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [15:0] inten;
      lo = 8'($urandom_range(0, 255));
      hi = 8'($urandom_range(0, 255));
      inten = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) begin
         hi[7:6] = 2'b00;
      end
      return {inten, hi, lo};
   endfunction

   // Mostly well-formed packets, some with a bad checksum, some cut short.
   task automatic push_random_packet();
      int kind;
      int i;
      kind = $urandom_range(0, 19);
      push_noise($urandom_range(0, 3));
      if (kind < 17) begin
         push_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     random_reading(), random_reading(), random_reading(),
                     random_reading(),
                     (kind < 14) ? 16'd0 : 16'($urandom_range(1, 65535)));
      end else begin
         push_byte(gen_sync);
         for (i = 0; i < $urandom_range(1, 20); i++) begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Wait until every byte is taken and every word has come out, then let the
   // block settle before anything changes its setup.
   task automatic wait_drained();
      while (bytes_taken != bytes_pushed || readings_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == CSR_SYNC_BYTE) begin
         gen_sync = value;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random traffic of roughly the given byte count; trailing noise as long as
   // a packet leaves the deframer hunting again.
   task automatic run_random(input int count);
      int start;
      start = bytes_pushed;
      while (bytes_pushed - start < count) begin
         push_random_packet();
      end
      push_noise(PKT_BYTES);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: full-scale reading, both flag bits, a sync value inside
      // the data, index wrap below the base and both checksum bytes wrong.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_packet(8'd160, 16'hFFFF, {16'hFFFF, 8'h3F, 8'hFF}, {16'h1234, 8'h85, 8'h10},
                  {16'hABCD, 8'h40, 8'h22}, 32'h0000_0000, 16'h0000);
      push_packet(8'd159, 16'h0000, {16'h00FA, 8'h3A, 8'hFA}, 32'hC0FF_C0FF,
                  32'h0001_0001, 32'hFFFF_FF00, 16'h0000);
      push_packet(8'h00, 16'h1A2B, random_reading(), random_reading(),
                  random_reading(), random_reading(), 16'h8000);
      push_packet(8'hFF, 16'hB2A1, random_reading(), random_reading(),
                  random_reading(), random_reading(), 16'h0001);
      wait_drained();

      // Both registers at their low end.
      write_reg(CSR_SYNC_BYTE, 8'h00);
      write_reg(CSR_INDEX_BASE, 8'h00);
      push_byte(8'hFF);
      push_packet(8'hFF, 16'h8001, random_reading(), random_reading(),
                  random_reading(), random_reading(), 16'h0000);
      push_packet(8'h00, 16'h7FFE, 32'hFFFF_3FFF, 32'hFFFF_3FFF, 32'hFFFF_FFFF,
                  32'h0000_0000, 16'h0000);
      wait_drained();

      // Both registers at their high end.
      write_reg(CSR_SYNC_BYTE, 8'hFF);
      write_reg(CSR_INDEX_BASE, 8'hFF);
      push_packet(8'h00, 16'h0040, random_reading(), random_reading(),
                  random_reading(), random_reading(), 16'h0000);
      push_packet(8'hFE, 16'h0040, random_reading(), random_reading(),
                  random_reading(), random_reading(), 16'h0000);
      wait_drained();

      // Long output stall while packets keep arriving, so the input backs up.
      write_reg(CSR_SYNC_BYTE, 8'($urandom_range(0, 255)));
      write_reg(CSR_INDEX_BASE, 8'($urandom_range(0, 255)));
      hold_asks++;
      repeat (4) begin
         push_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     random_reading(), random_reading(), random_reading(),
                     random_reading(), 16'h0000);
      end
      wait_drained();

      // Last stretch runs at full rate with no idling on either side.
      idle_on = 1'b0;
      write_reg(CSR_SYNC_BYTE, SYNC_BYTE_RESET);
      write_reg(CSR_INDEX_BASE, INDEX_BASE_RESET);
      run_random(20);

      repeat (20) @(negedge clock);
      if (readings_due.size() != 0) begin
         report_mismatch($sformatf("%0d words never arrived", readings_due.size()));
      end
      $display("tb: %0d bytes sent, %0d good packets, %0d checksum errors, %0d words checked",
               bytes_taken, good_packets, bad_packets, words_checked);
      $display("tb: sync/base at reset, low, high and random values; long output stall");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
